// ----- rtl/core/content_length_header_check_assert.svh -----
// Assertion macros shared by the content-length checker RTL
`ifndef CONTENT_LENGTH_HEADER_CHECK_ASSERT_SVH
`define CONTENT_LENGTH_HEADER_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, masked while reset is high
`define CLH_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("content_length_header_check: assertion failed");
// Checked property, also checked during reset
`define CLH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("content_length_header_check: assertion failed");
`else
`define CLH_ASSERT(lbl, clk, rst, prop)
`define CLH_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/clh_pkg.sv -----
// Types and constants of the content-length header checker
`default_nettype none
package clh_pkg;

  typedef enum logic [1:0] {
    MODE_NAME     = 2'd0,
    MODE_VALUE    = 2'd1,
    MODE_END_HDR  = 2'd2,
    MODE_END_LIST = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_ABSENT  = 2'd0,
    ST_VALID   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // value syntax phases
  typedef enum logic [2:0] {
    PH_LEAD   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_TRAIL  = 3'b100
  } phase_t;

  // classified item, front to back
  typedef struct packed {
    mode_t      mode;
    logic       is_digit;
    logic       is_space;
    logic [3:0] digit;
    logic       name_hit;
  } item_t;

  localparam int          LENGTH_W     = 64;
  localparam logic [3:0]  NAME_LEN     = 4'd14;
  localparam logic [3:0]  NAME_POS_MAX = 4'd15;
  localparam logic [7:0]  CHAR_0       = 8'h30;
  localparam logic [7:0]  CHAR_9       = 8'h39;
  localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0]  CASE_OFFSET  = 8'h20;

  // "content-length", one byte per position
  function automatic logic [7:0] target_byte(input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      4'd0:    b = "c";
      4'd1:    b = "o";
      4'd2:    b = "n";
      4'd3:    b = "t";
      4'd4:    b = "e";
      4'd5:    b = "n";
      4'd6:    b = "t";
      4'd7:    b = "-";
      4'd8:    b = "l";
      4'd9:    b = "e";
      4'd10:   b = "n";
      4'd11:   b = "g";
      4'd12:   b = "t";
      4'd13:   b = "h";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/clh_front.sv -----
// Front end: classifies bytes and matches the header name
`default_nettype none
module clh_front
  import clh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] data_byte,
  output item_t           item
);

  logic [3:0] name_pos;
  logic [3:0] name_pos_next;
  logic       name_mismatch;
  logic       name_mismatch_next;
  logic [7:0] lower;
  mode_t      m;

  assign m = mode_t'(mode);

  always_comb begin
    lower = data_byte;
    if (data_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      lower = data_byte + CASE_OFFSET;
    end
  end

  always_comb begin
    item.mode     = m;
    item.is_digit = data_byte inside {[CHAR_0:CHAR_9]};
    item.is_space = data_byte inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    item.digit    = data_byte[3:0];
    item.name_hit = !name_mismatch && (name_pos == NAME_LEN);
  end

  always_comb begin
    name_pos_next      = name_pos;
    name_mismatch_next = name_mismatch;
    case (m)
      MODE_NAME: begin
        if (name_pos < NAME_LEN) begin
          if (lower != target_byte(name_pos)) begin
            name_mismatch_next = 1'b1;
          end
        end else begin
          name_mismatch_next = 1'b1;
        end
        if (name_pos < NAME_POS_MAX) begin
          name_pos_next = name_pos + 4'd1;
        end
      end
      MODE_VALUE: begin
      end
      MODE_END_HDR, MODE_END_LIST: begin
        name_pos_next      = '0;
        name_mismatch_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_pos      <= '0;
      name_mismatch <= 1'b0;
    end else if (take) begin
      name_pos      <= name_pos_next;
      name_mismatch <= name_mismatch_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/clh_queue.sv -----
// Two-entry queue between front and back
`default_nettype none
module clh_queue
  import clh_pkg::*;
`include "content_length_header_check_assert.svh"
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output logic       full,
  output logic       head_valid,
  output item_t      head
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `CLH_ASSERT(a_count_bound, clk, rst, count <= 2'd2)
  `CLH_ASSERT(a_no_pop_empty, clk, rst, pop |-> count != 2'd0)
  `CLH_ASSERT(a_no_push_full, clk, rst, push |-> count != 2'd2)

endmodule
`default_nettype wire

// ----- rtl/core/clh_back.sv -----
// Back end: value parsing, list verdict and result register
`default_nettype none
module clh_back
  import clh_pkg::*;
`include "content_length_header_check_assert.svh"
#(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire item_t               item,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [LENGTH_W-1:0]      length
);

  localparam int AW = LENGTH_BITS + 4;

  phase_t                 value_phase, value_phase_next;
  logic [LENGTH_BITS-1:0] value_accum, value_accum_next;
  logic                   value_bad, value_bad_next;
  logic                   length_seen, length_seen_next;
  logic [LENGTH_BITS-1:0] stored_length, stored_length_next;
  logic                   list_bad, list_bad_next;
  logic [AW-1:0]          acc_ext;
  logic [AW-1:0]          acc_next_wide;
  logic                   acc_ovf;
  logic                   is_end;
  status_t                status_reg;

  assign is_end = (item.mode == MODE_END_LIST);
  assign pop    = item_valid && (!is_end || !out_valid || !out_stall);

  // accum * 10 + digit by shifts; overflow shows in the top four bits
  assign acc_ext       = AW'(value_accum);
  assign acc_next_wide = (acc_ext << 3) + (acc_ext << 1) + AW'(item.digit);
  assign acc_ovf       = |acc_next_wide[AW-1:LENGTH_BITS];

  always_comb begin
    value_phase_next   = value_phase;
    value_accum_next   = value_accum;
    value_bad_next     = value_bad;
    length_seen_next   = length_seen;
    stored_length_next = stored_length;
    list_bad_next      = list_bad;
    case (item.mode)
      MODE_NAME: begin
      end
      MODE_VALUE: begin
        if (!value_bad) begin
          case (value_phase)
            PH_LEAD: begin
              if (item.is_digit) begin
                value_accum_next = LENGTH_BITS'(item.digit);
                value_phase_next = PH_DIGITS;
              end else if (!item.is_space) begin
                value_bad_next = 1'b1;
              end
            end
            PH_DIGITS: begin
              if (item.is_digit) begin
                if (acc_ovf) begin
                  value_bad_next = 1'b1;
                end else begin
                  value_accum_next = acc_next_wide[LENGTH_BITS-1:0];
                end
              end else if (item.is_space) begin
                value_phase_next = PH_TRAIL;
              end else begin
                value_bad_next = 1'b1;
              end
            end
            default: begin
              if (!item.is_space) begin
                value_bad_next = 1'b1;
              end
            end
          endcase
        end
      end
      MODE_END_HDR: begin
        if (item.name_hit) begin
          if (value_bad || value_phase == PH_LEAD) begin
            list_bad_next = 1'b1;
          end else if (length_seen && value_accum != stored_length) begin
            list_bad_next = 1'b1;
          end else begin
            stored_length_next = value_accum;
            length_seen_next   = 1'b1;
          end
        end
        value_phase_next = PH_LEAD;
        value_accum_next = '0;
        value_bad_next   = 1'b0;
      end
      MODE_END_LIST: begin
        value_phase_next   = PH_LEAD;
        value_accum_next   = '0;
        value_bad_next     = 1'b0;
        length_seen_next   = 1'b0;
        stored_length_next = '0;
        list_bad_next      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_phase   <= PH_LEAD;
      value_accum   <= '0;
      value_bad     <= 1'b0;
      length_seen   <= 1'b0;
      stored_length <= '0;
      list_bad      <= 1'b0;
    end else if (pop) begin
      value_phase   <= value_phase_next;
      value_accum   <= value_accum_next;
      value_bad     <= value_bad_next;
      length_seen   <= length_seen_next;
      stored_length <= stored_length_next;
      list_bad      <= list_bad_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      if (list_bad) begin
        status_reg <= ST_INVALID;
        length     <= '0;
      end else if (length_seen) begin
        status_reg <= ST_VALID;
        length     <= LENGTH_W'(stored_length);
      end else begin
        status_reg <= ST_ABSENT;
        length     <= '0;
      end
    end
  end

  assign status = status_reg;

  `CLH_ASSERT(a_end_gives_result, clk, rst, pop && is_end |=> out_valid)
  `CLH_ASSERT(a_len_zero_unless_valid, clk, rst,
    out_valid && status_reg != ST_VALID |-> length == '0)

endmodule
`default_nettype wire

// ----- rtl/core/content_length_header_check.sv -----
// Top level of the content-length header checker
//
// Input channel (in_valid / in_stall): one item per transfer, mode gives
// its kind (name byte, value byte, end of header, end of list) and
// data_byte the byte for the first two kinds.
// Output channel (out_valid / out_stall): one result per end-of-list item,
// status (absent, valid, invalid) and length, zero unless status is valid.
// Throughput: one item per cycle sustained while the queue is not full; the
// front classifier and the back parser each take one item a cycle, joined
// by a two-entry queue. An accepted end-of-list item passes the queue
// register and then the result register, which shows its result.
// A stalled result holds; items keep flowing until the queue fills, which
// happens only when an end-of-list item waits behind a held result.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// clears all name, value and list state; the first item may follow at once.
`default_nettype none
module content_length_header_check
  import clh_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          mode,
  input  wire logic [7:0]          data_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [LENGTH_W-1:0]      length
);

  item_t front_item;
  item_t head;
  logic  q_full;
  logic  head_valid;
  logic  take;
  logic  pop;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  clh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (mode),
    .data_byte (data_byte),
    .item      (front_item)
  );

  clh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_item  (front_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  clh_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (head_valid),
    .item       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .length     (length)
  );

endmodule
`default_nettype wire
